// File: hw/rtl/base92_encoder_macros.svh
// Assertion macros shared by the Base92 encoder RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef BASE92_ENCODER_MACROS_SVH
`define BASE92_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B92_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B92_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/b92_pkg.sv
// Package for the Base92 encoder: job type, constants and alphabet mapping.
// Used by every RTL module of the encoder; depends on nothing.
`default_nettype none

package b92_pkg;

    // Field widths.
    localparam int B92_BYTE_W    = 8;
    localparam int B92_CHAR_W    = 7;
    localparam int B92_PEND_W    = 12;
    localparam int B92_CNT_W     = 4;
    localparam int B92_GROUP_W   = 13;
    localparam int B92_SINGLE_W  = 6;
    // Leftover bit counts of at least this size are flushed as a full group.
    localparam int B92_SPLIT_CNT = 7;

    // Radix and its reciprocal: q = (g * B92_RECIP) >> B92_RECIP_SH is exact
    // for every 13-bit g.
    localparam int B92_RADIX     = 91;
    localparam int B92_RECIP     = 11523;
    localparam int B92_RECIP_W   = 14;
    localparam int B92_RECIP_SH  = 20;
    localparam int B92_PROD_W    = B92_GROUP_W + B92_RECIP_W;

    // Default depth of the job queue between front and back.
    localparam int B92_QUEUE_DEPTH = 4;

    // One unit of work for the back end: a 13-bit group (two characters)
    // or a 6-bit value (one character).
    typedef struct packed {
        logic                   single;
        logic [B92_GROUP_W-1:0] value;
        logic                   last;
    } t_job;

    // Map an index 0..90 to its character: '!' upward, skipping '"' and '`'.
    function automatic logic [B92_CHAR_W-1:0] b92_alpha(input logic [B92_CHAR_W-1:0] idx);
        logic [B92_CHAR_W-1:0] c;
        c = idx + 7'd33;
        if (idx >= 7'd1) begin
            c = c + 7'd1;
        end
        if (idx >= 7'd62) begin
            c = c + 7'd1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/b92_front.sv
// Front end of the Base92 encoder: accepts bytes, tracks pending bits and
// turns them into group and flush jobs. Depends on b92_pkg and the macro header.
`default_nettype none
`include "base92_encoder_macros.svh"

module b92_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [b92_pkg::B92_BYTE_W-1:0]   i_data_byte,
    input  wire logic                             i_last_byte,
    output logic                                  o_push,
    output b92_pkg::t_job                         o_job,
    input  wire logic                             i_full
);
    import b92_pkg::*;

    logic [B92_PEND_W-1:0]           r_pbits, n_pbits;
    logic [B92_CNT_W-1:0]            r_cnt, n_cnt;
    logic                            r_hold_v, n_hold_v;
    t_job                            r_hold, n_hold;

    logic                            w_accept;
    logic [B92_PEND_W+B92_BYTE_W-1:0] w_acc;
    logic [B92_CNT_W:0]              w_cnt8;
    logic                            w_has_group;
    logic [2:0]                      w_shift;
    logic [B92_GROUP_W-1:0]          w_group;
    logic [B92_CNT_W-1:0]            w_rem;
    logic [B92_PEND_W-1:0]           w_rem_bits;
    logic                            w_has_flush;
    t_job                            w_flush;
    t_job                            w_first;

    // A byte is taken only when no second job waits and the queue has room.
    assign o_in_ready = !r_hold_v && !i_full;
    assign w_accept   = i_in_valid && o_in_ready;

    // Split the accumulator into a complete group and the leftover bits.
    always_comb begin
        w_acc       = {r_pbits, i_data_byte};
        w_cnt8      = {1'b0, r_cnt} + (B92_CNT_W+1)'(B92_BYTE_W);
        w_has_group = w_cnt8 >= (B92_CNT_W+1)'(B92_GROUP_W);
        w_shift     = 3'(w_cnt8 - (B92_CNT_W+1)'(B92_GROUP_W));
        w_group     = B92_GROUP_W'(w_acc >> w_shift);
        w_rem       = w_has_group ? B92_CNT_W'(w_cnt8 - (B92_CNT_W+1)'(B92_GROUP_W))
                                  : B92_CNT_W'(w_cnt8);
        w_rem_bits  = w_acc[B92_PEND_W-1:0] & ~({B92_PEND_W{1'b1}} << w_rem);
    end

    // Flush job for the final byte: padded to a single symbol or a full group.
    always_comb begin
        w_has_flush    = i_last_byte && (w_rem != '0);
        w_flush.single = w_rem < B92_CNT_W'(B92_SPLIT_CNT);
        w_flush.last   = 1'b1;
        if (w_flush.single) begin
            w_flush.value = B92_GROUP_W'(B92_SINGLE_W'(B92_GROUP_W'(w_rem_bits)
                            << (B92_CNT_W'(B92_SINGLE_W) - w_rem)));
        end else begin
            w_flush.value = B92_GROUP_W'(w_rem_bits) << (B92_CNT_W'(B92_GROUP_W) - w_rem);
        end
        if (w_has_group) begin
            w_first.single = 1'b0;
            w_first.value  = w_group;
            w_first.last   = i_last_byte && !w_has_flush;
        end else begin
            w_first = w_flush;
        end
    end

    // Push the held job first; otherwise push what the accepted byte produced.
    always_comb begin
        if (r_hold_v) begin
            o_push = !i_full;
            o_job  = r_hold;
        end else begin
            o_push = w_accept && (w_has_group || w_has_flush);
            o_job  = w_first;
        end
    end

    // Next pending state and the second-job holding register.
    always_comb begin
        n_pbits  = r_pbits;
        n_cnt    = r_cnt;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        if (r_hold_v && !i_full) begin
            n_hold_v = 1'b0;
        end
        if (w_accept) begin
            n_pbits = i_last_byte ? '0 : w_rem_bits;
            n_cnt   = i_last_byte ? '0 : w_rem;
            if (w_has_group && w_has_flush) begin
                n_hold_v = 1'b1;
                n_hold   = w_flush;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits  <= '0;
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_pbits  <= n_pbits;
            r_cnt    <= n_cnt;
            r_hold_v <= n_hold_v;
        end
        r_hold <= n_hold;
    end

    // Pending count never exceeds twelve bits.
    `B92_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= B92_CNT_W'(B92_PEND_W), "pending count out of range")
    // A held job is always a final flush job.
    `B92_ASSERT_NOW(a_hold_last, i_clk, i_rst_n, r_hold_v, r_hold.last, "held job not marked final")
    // A final byte always produces at least one job.
    `B92_ASSERT_NOW(a_last_pushes, i_clk, i_rst_n, w_accept && i_last_byte, o_push, "final byte produced no job")

endmodule

`default_nettype wire

// File: hw/rtl/b92_queue.sv
// Job queue between front and back end of the Base92 encoder.
// Small first-in first-out buffer of t_job words; depends on b92_pkg.
`default_nettype none
`include "base92_encoder_macros.svh"

module b92_queue #(
    parameter int DEPTH = b92_pkg::B92_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  b92_pkg::t_job      i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output b92_pkg::t_job      o_job
);
    import b92_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = r_count == CNT_W'(DEPTH);
    assign o_empty   = r_count == '0;
    assign o_job     = r_mem[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // The front never pushes into a full queue; a lost job is a lost word.
    `B92_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    // The fill count stays within the depth.
    `B92_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "queue count overflow")
    // Equal pointers mean empty or full, nothing in between.
    `B92_ASSERT_NOW(a_ptr_match, i_clk, i_rst_n, r_wptr == r_rptr, o_empty || o_full, "pointer and count disagree")

endmodule

`default_nettype wire

// File: hw/rtl/b92_back.sv
// Back end of the Base92 encoder: divides groups by 91 with a reciprocal multiply,
// maps to characters and sends one word per cycle unless the output stalls. Depends on b92_pkg.
`default_nettype none
`include "base92_encoder_macros.svh"

module b92_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_empty,
    input  b92_pkg::t_job                         i_job,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [b92_pkg::B92_CHAR_W-1:0]        o_code_char,
    output logic                                  o_last_char
);
    import b92_pkg::*;

    // Product stage.
    logic                     r_p_v;
    t_job                     r_p_job;
    logic [B92_PROD_W-1:0]    r_p_prod;

    // Character stage, which also drives the output port.
    logic                     r_d_v;
    logic [B92_CHAR_W-1:0]    r_d_c0, r_d_c1;
    logic                     r_d_two;
    logic                     r_d_last;
    logic                     r_d_phase;

    logic                     w_d_final;
    logic                     w_d_free;
    logic                     w_p_free;
    logic [B92_CHAR_W-1:0]    w_q;
    logic [B92_GROUP_W-1:0]   w_qx;
    logic [B92_CHAR_W-1:0]    w_r;
    logic [B92_CHAR_W-1:0]    n_c0, n_c1;

    // Stage handshakes: each stage moves when the one after it frees up.
    assign w_d_final = !r_d_two || r_d_phase;
    assign w_d_free  = !r_d_v || (i_out_ready && w_d_final);
    assign w_p_free  = !r_p_v || w_d_free;
    assign o_pop     = !i_empty && w_p_free;

    // Quotient from the product, remainder by subtracting q * 91.
    always_comb begin
        w_q  = r_p_prod[B92_PROD_W-1:B92_RECIP_SH];
        w_qx = B92_GROUP_W'(w_q) * B92_GROUP_W'(B92_RADIX);
        w_r  = B92_CHAR_W'(r_p_job.value - w_qx);
        if (r_p_job.single) begin
            n_c0 = b92_alpha(B92_CHAR_W'(r_p_job.value[B92_SINGLE_W-1:0]));
        end else begin
            n_c0 = b92_alpha(w_q);
        end
        n_c1 = b92_alpha(w_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v     <= 1'b0;
            r_d_v     <= 1'b0;
            r_d_phase <= 1'b0;
        end else begin
            if (w_p_free) begin
                r_p_v <= o_pop;
            end
            if (w_d_free) begin
                r_d_v     <= r_p_v;
                r_d_phase <= 1'b0;
            end else if (i_out_ready) begin
                r_d_phase <= 1'b1;
            end
        end
        // Payload registers.
        if (o_pop) begin
            r_p_job  <= i_job;
            r_p_prod <= B92_PROD_W'(i_job.value) * B92_PROD_W'(B92_RECIP);
        end
        if (w_d_free && r_p_v) begin
            r_d_c0   <= n_c0;
            r_d_c1   <= n_c1;
            r_d_two  <= !r_p_job.single;
            r_d_last <= r_p_job.last;
        end
    end

    // Output word: first or second character of the current job.
    assign o_out_valid = r_d_v;
    assign o_code_char = r_d_phase ? r_d_c1 : r_d_c0;
    assign o_last_char = r_d_last && w_d_final;

    // The quotient of a 13-bit group is a valid alphabet index.
    `B92_ASSERT_NOW(a_q_range, i_clk, i_rst_n, r_p_v && !r_p_job.single, w_q <= B92_CHAR_W'(B92_RADIX - 1), "quotient out of range")
    // The remainder is a valid alphabet index.
    `B92_ASSERT_NOW(a_r_range, i_clk, i_rst_n, r_p_v && !r_p_job.single, w_r <= B92_CHAR_W'(B92_RADIX - 1), "remainder out of range")
    // Second phase only exists for two-character jobs.
    `B92_ASSERT_NOW(a_phase_two, i_clk, i_rst_n, r_d_v && r_d_phase, r_d_two, "second character of a single job")

endmodule

`default_nettype wire

// File: hw/rtl/base92_encoder.sv
// Top level of the Base92 encoder: front end, job queue and back end.
// Depends on b92_pkg, b92_front, b92_queue and b92_back.
//
//   Channel | Handshake                   | Word
//   --------+-----------------------------+-----------------------------------
//   input   | i_in_valid / o_in_ready     | i_data_byte, i_last_byte
//   output  | o_out_valid / i_out_ready   | o_code_char, o_last_char
//
// A byte that both completes a group and ends the message holds the input
// while its flush job is queued.
// The back end sends one character per cycle while the output is ready, so the
// single output port sets the throughput.
// A job passes through the queue, the product stage and the character stage.
// Reset is synchronous and active low; it empties the queue and clears pending bits.
// A stalled output fills the queue, after which the input drops ready.
`default_nettype none

module base92_encoder #(
    parameter int QUEUE_DEPTH = b92_pkg::B92_QUEUE_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [b92_pkg::B92_BYTE_W-1:0]   i_data_byte,
    input  wire logic                             i_last_byte,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [b92_pkg::B92_CHAR_W-1:0]        o_code_char,
    output logic                                  o_last_char
);
    import b92_pkg::*;

    logic  w_push;
    t_job  w_push_job;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;
    t_job  w_head_job;

    // Byte intake and job generation.
    b92_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (w_push),
        .o_job       (w_push_job),
        .i_full      (w_full)
    );

    // Jobs waiting for the back end.
    b92_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    // Division, character mapping and output.
    b92_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_code_char (o_code_char),
        .o_last_char (o_last_char)
    );

endmodule

`default_nettype wire
